### hw/rtl/gdb_pkg.sv
package gdb_pkg;

  localparam int TableLen = 32;
  localparam int CordicStagesDef = 24;
  localparam logic signed [31:0] CosInit = 32'sd652032874;
  localparam logic [21:0] DistMul = 22'd3360135;
  localparam logic [21:0] DistMax = 22'd4194303;

  localparam logic [1:0] CfgOwnLat = 2'd0;
  localparam logic [1:0] CfgOwnLon = 2'd1;
  localparam logic [1:0] CfgRadius = 2'd2;

  typedef struct packed {
    logic signed [31:0] target_latitude;
    logic signed [31:0] target_longitude;
  } in_item_t;

  typedef struct packed {
    logic [21:0]        distance;
    logic signed [15:0] bearing;
    logic               in_range;
  } out_item_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] t [0:TableLen-1];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
          32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
          32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
          32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
          32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
    return t[i];
  endfunction

endpackage

### hw/rtl/geo_distance_bearing_range_check_core.sv
// Flat-earth distance and bearing from the own position to a stream of targets.
// Input channel in_valid/in_ready carries one target position per item; result
// channel out_valid/out_ready carries distance (1/256 NM), bearing (65536 per
// turn) and the range flag. Configuration writes cfg_we/cfg_addr/cfg_wdata
// set own latitude, own longitude and display radius; write only when idle.
// Throughput: one item per cycle unless the receiver stalls; the rate is set
// by the two unrolled CORDIC pipelines (cosine of mean latitude, then
// vectoring) and the 3-step distance scaling.
// The whole pipeline advances as one when the output register is free or
// taken; when the receiver stalls every stage holds and in_ready falls, so
// nothing is lost or repeated.
// Synchronous reset clears all valid bits and the configuration registers.
// in_ready = out_ready or output register empty, or any bubble downstream is
// not exploited: the pipe moves whenever the last stage can hand over.
module geo_distance_bearing_range_check_core
  import gdb_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int NS = CORDIC_STAGES;

  logic signed [31:0] own_lat_r, own_lon_r;
  logic [20:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_lat_r <= '0;
      own_lon_r <= '0;
      radius_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CfgOwnLat: own_lat_r <= cfg_wdata;
        CfgOwnLon: own_lon_r <= cfg_wdata;
        CfgRadius: radius_r  <= cfg_wdata[20:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: differences and folded mean latitude
  logic               v0_r;
  logic signed [31:0] dlat0_r, dlon0_r, mlat0_r;
  logic signed [32:0] sum_lat;
  logic signed [31:0] mlat_raw;
  assign sum_lat = {in_data.target_latitude[31], in_data.target_latitude}
                 + {own_lat_r[31], own_lat_r};
  assign mlat_raw = sum_lat[32:1];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dlat0_r <= in_data.target_latitude - own_lat_r;
      dlon0_r <= in_data.target_longitude - own_lon_r;
      if (mlat_raw > 32'sh40000000 || mlat_raw < -32'sh40000000)
        mlat0_r <= mlat_raw + 32'sh80000000;
      else
        mlat0_r <= mlat_raw;
    end
  end

  // cosine CORDIC pipeline
  logic               cv_r   [0:NS];
  logic signed [33:0] cx_r   [0:NS];
  logic signed [33:0] cy_r   [0:NS];
  logic signed [33:0] cz_r   [0:NS];
  logic signed [31:0] cdlat_r[0:NS];
  logic signed [31:0] cdlon_r[0:NS];

  always_comb begin
    cv_r[0]    = v0_r;
    cx_r[0]    = 34'(CosInit);
    cy_r[0]    = '0;
    cz_r[0]    = 34'(mlat0_r);
    cdlat_r[0] = dlat0_r;
    cdlon_r[0] = dlon0_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cos
    logic signed [33:0] at;
    assign at = (i < TableLen) ? 34'(atan_val(i)) : '0;
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (adv) cv_r[i+1] <= cv_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cdlat_r[i+1] <= cdlat_r[i];
        cdlon_r[i+1] <= cdlon_r[i];
        if (i >= TableLen) begin
          cx_r[i+1] <= cx_r[i];
          cy_r[i+1] <= cy_r[i];
          cz_r[i+1] <= cz_r[i];
        end else if (!cz_r[i][33]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - at;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + at;
        end
      end
    end
  end

  // stage M: clamp cosine, multiply east offset
  logic [30:0] cclamp;
  always_comb begin
    if (cx_r[NS][33]) cclamp = '0;
    else if (cx_r[NS] > 34'sh40000000) cclamp = 31'h40000000;
    else cclamp = cx_r[NS][30:0];
  end

  logic               mv_r;
  logic signed [63:0] mprod_r;
  logic signed [31:0] mdlat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (adv) mv_r <= cv_r[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mprod_r <= 64'(cdlon_r[NS]) * $signed({1'b0, cclamp});
      mdlat_r <= cdlat_r[NS];
    end
  end

  // stage P: pre-rotation into right half-plane
  logic signed [49:0] px, py;
  assign px = {{2{mdlat_r[31]}}, mdlat_r, 16'h0000};
  assign py = 50'(mprod_r >>> 14);

  logic               vv_r [0:NS];
  logic signed [50:0] vx_r [0:NS];
  logic signed [50:0] vy_r [0:NS];
  logic        [31:0] vz_r [0:NS];
  logic               vnz_r[0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) vv_r[0] <= 1'b0;
    else if (adv) vv_r[0] <= mv_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      vnz_r[0] <= (px != 0) || (py != 0);
      if (px[49]) begin
        vx_r[0] <= -51'(px);
        vy_r[0] <= -51'(py);
        vz_r[0] <= 32'h80000000;
      end else begin
        vx_r[0] <= 51'(px);
        vy_r[0] <= 51'(py);
        vz_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    logic [31:0] at;
    assign at = (i < TableLen) ? atan_val(i) : '0;
    always_ff @(posedge clk) begin
      if (!rst_n) vv_r[i+1] <= 1'b0;
      else if (adv) vv_r[i+1] <= vv_r[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        vnz_r[i+1] <= vnz_r[i];
        if (i >= TableLen) begin
          vx_r[i+1] <= vx_r[i];
          vy_r[i+1] <= vy_r[i];
          vz_r[i+1] <= vz_r[i];
        end else if (!vy_r[i][50]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + at;
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - at;
        end
      end
    end
  end

  // distance scaling: split 39x22 multiply into two partial products
  logic [38:0] magq;
  assign magq = vx_r[NS][50] ? '0 : vx_r[NS][50:12];

  logic        d1v_r, d1nz_r;
  logic [15:0] d1brg_r;
  logic [41:0] plo_r;
  logic [41:0] phi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d1v_r <= 1'b0;
    else if (adv) d1v_r <= vv_r[NS];
  end
  logic [31:0] zr;
  assign zr = vz_r[NS] + 32'h00008000;
  always_ff @(posedge clk) begin
    if (adv) begin
      d1nz_r  <= vnz_r[NS];
      d1brg_r <= zr[31:16];
      plo_r   <= 42'({1'b0, magq[19:0]} * DistMul);
      phi_r   <= 42'(magq[38:20] * DistMul);
    end
  end

  logic        d2v_r, d2nz_r;
  logic [15:0] d2brg_r;
  logic [62:0] dsum_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d2v_r <= 1'b0;
    else if (adv) d2v_r <= d1v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d2nz_r  <= d1nz_r;
      d2brg_r <= d1brg_r;
      dsum_r  <= {phi_r, 20'h00000} + 63'(plo_r) + (63'd1 << 35);
    end
  end

  logic [26:0] dq;
  logic [21:0] dist_sat;
  assign dq = dsum_r[62:36];
  always_comb begin
    if (!d2nz_r) dist_sat = '0;
    else if (dq > 27'(DistMax)) dist_sat = DistMax;
    else dist_sat = dq[21:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= d2v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.distance <= dist_sat;
      out_data.bearing  <= d2nz_r ? d2brg_r : '0;
      out_data.in_range <= {1'b0, dist_sat} <= {1'b0, radius_r, 1'b0};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready mismatch");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.distance == 22'd0 |-> out_data.in_range)
    else $error("zero distance out of range");

endmodule

### dv/geo_distance_bearing_range_check_core_test.sv
module geo_distance_bearing_range_check_core_test;
  import gdb_pkg::*;

  localparam int Stages = CordicStagesDef;
  localparam int Latency = 2 * Stages + 6;
  localparam longint CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  geo_distance_bearing_range_check_core #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  logic signed [31:0] own_lat;
  logic signed [31:0] own_lon;
  logic [20:0]        radius;

  in_item_t  target_queue[$];
  out_item_t fix_queue[$];
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_send;
  bit  in_accepted;
  int  errors;
  int  fixes_seen;
  int  in_range_seen;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cos_of_mean(longint a);
    longint x, y, z, nx;
    x = CosInit;
    y = 0;
    if (a > 64'sh40000000 || a < -64'sh40000000) begin
      a = longint'(signed'(32'(a + 64'sh80000000)));
    end
    z = a;
    for (int i = 0; i < Stages && i < TableLen; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i);
        y = y + shr(x, i);
        z = z - longint'(atan_val(i));
      end else begin
        nx = x + shr(y, i);
        y = y - shr(x, i);
        z = z + longint'(atan_val(i));
      end
      x = nx;
    end
    if (x < 0) x = 0;
    if (x > 64'sh40000000) x = 64'sh40000000;
    return x;
  endfunction

  function automatic out_item_t predict_fix(in_item_t t);
    out_item_t r;
    longint dlat, dlon, mlat, c, x, y, nx;
    logic [31:0] z;
    logic [63:0] d;
    logic [31:0] rz;
    dlat = longint'(signed'(32'(longint'(t.target_latitude) - longint'(own_lat))));
    dlon = longint'(signed'(32'(longint'(t.target_longitude) - longint'(own_lon))));
    mlat = longint'(signed'(32'((longint'(own_lat) + longint'(t.target_latitude)) >>> 1)));
    c = cos_of_mean(mlat);
    x = dlat * 65536;
    y = shr(dlon * c, 14);
    z = '0;
    d = '0;
    r.bearing = '0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < Stages && i < TableLen; i++) begin
        if (y >= 0) begin
          nx = x + shr(y, i);
          y = y - shr(x, i);
          z = z + atan_val(i);
        end else begin
          nx = x - shr(y, i);
          y = y + shr(x, i);
          z = z - atan_val(i);
        end
        x = nx;
      end
      if (x < 0) x = 0;
      d = (64'(shr(x, 12)) * 64'(DistMul) + (64'd1 << 35)) >> 36;
      if (d > 64'(DistMax)) d = 64'(DistMax);
      rz = z + 32'h8000;
      r.bearing = rz[31:16];
    end
    r.distance = d[21:0];
    r.in_range = (d <= 2 * 64'(radius));
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_accepted) begin
        if (target_queue.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data <= target_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      in_accepted <= in_valid && in_ready;
      if (in_valid && in_ready) fix_queue.push_back(predict_fix(in_data));
      if (out_valid && out_ready) begin
        if (fix_queue.size() == 0) begin
          $display("%0t unexpected item %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          automatic out_item_t e = fix_queue.pop_front();
          fixes_seen <= fixes_seen + 1;
          in_range_seen <= in_range_seen + out_data.in_range;
          if (out_data.distance !== e.distance || out_data.bearing !== e.bearing ||
              out_data.in_range !== e.in_range) begin
            $display("%0t mismatch: expected %p actual %p", $time, e, out_data);
            errors <= errors + 1;
          end
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CfgOwnLat: own_lat = val;
      CfgOwnLon: own_lon = val;
      default:   radius = val[20:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (target_queue.size() == 0 && !in_valid);
    wait (fix_queue.size() == 0);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_lat();
    case ($urandom_range(3))
      0: return 32'($urandom_range(32'h7FFFFFFF)) - 32'sh40000000;
      1: return $urandom_range(1) ? 32'sh40000000 : 32'shC0000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t near_target();
    in_item_t t;
    int spread;
    spread = 1 << $urandom_range(30);
    t.target_latitude = own_lat + 32'(int'($urandom_range(spread)) - spread / 2);
    t.target_longitude = own_lon + 32'(int'($urandom_range(spread)) - spread / 2);
    return t;
  endfunction

  task automatic queue_target(logic [31:0] la, logic [31:0] lo);
    in_item_t t;
    t.target_latitude = la;
    t.target_longitude = lo;
    target_queue.push_back(t);
  endtask

  task automatic random_phase(int n);
    in_item_t t;
    write_reg(CfgOwnLat, rand_lat());
    write_reg(CfgOwnLon, $urandom);
    write_reg(CfgRadius, $urandom_range(3) == 0 ? 32'h1FFFFF : 32'($urandom_range(32'h1FFFFF)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) t = near_target();
      else begin
        t.target_latitude = rand_lat();
        t.target_longitude = $urandom;
      end
      target_queue.push_back(t);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = CfgOwnLat;
    cfg_wdata = '0;
    own_lat = '0;
    own_lon = '0;
    radius = '0;
    hold_send = 1'b0;
    in_accepted = 1'b0;
    errors = 0;
    fixes_seen = 0;
    in_range_seen = 0;
    cycle_count = 0;
    send_idle_pct = 29;
    recv_idle_pct = 52;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_target(32'h0, 32'h0);
    queue_target(32'sh40000000, 32'h0);
    queue_target(32'shC0000000, 32'h0);
    queue_target(32'shC0000000, 32'sh7FFFFFFF);
    queue_target(32'sh40000000, 32'sh80000000);
    queue_target(32'h0, 32'sh80000000);
    queue_target(32'h0, 32'sh7FFFFFFF);
    queue_target(32'sh80000000, 32'h0);
    queue_target(32'shFFFFFFFF, 32'hFFFFFFFF);
    queue_target(32'hFFFFFFFF, 32'h0);
    drain();
    write_reg(CfgOwnLat, 32'sh40000000);
    write_reg(CfgOwnLon, 32'sh7FFFFFFF);
    write_reg(CfgRadius, 32'h1FFFFF);
    queue_target(32'sh40000000, 32'sh7FFFFFFF);
    queue_target(32'shC0000000, 32'sh80000000);
    queue_target(32'sh3FFFF000, 32'sh7FFFFFFF);
    queue_target(32'sh40001000, 32'sh7FFFF000);
    queue_target(32'sh7FFFFFFF, 32'h0);
    drain();
    write_reg(CfgOwnLat, 32'shC0000000);
    write_reg(CfgOwnLon, 32'sh80000000);
    write_reg(CfgRadius, 32'h0);
    queue_target(32'shC0000000, 32'sh80000000);
    queue_target(32'shC0000001, 32'sh80000000);
    queue_target(32'shBFFFFFFF, 32'sh80000001);
    queue_target(32'sh0, 32'sh0);
    drain();

    random_phase(350);
    send_idle_pct = 52;
    recv_idle_pct = 29;
    random_phase(350);
    hold_send = 1'b1;
    for (int i = 0; i < 20; i++) target_queue.push_back(near_target());
    wait (fix_queue.size() == 0);
    hold_send = 1'b0;
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(350);

    $display("covered %0d results (%0d in range) over directed and three random phases",
             fixes_seen, in_range_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
